/* sv/stepped_output_decay_macros.svh */
// Assertion macros shared by the stepped output decay checkers
`ifndef STEPPED_OUTPUT_DECAY_MACROS_SVH
`define STEPPED_OUTPUT_DECAY_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SOD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SOD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sod_pkg.sv */
// Types and constants shared by the stepped output decay block
package sod_pkg;

  localparam int CMD_W  = 16;
  localparam int FRAC_W = 16;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
  localparam logic [IDX_W-1:0] REG_STEP_LENGTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_DECAY_FACTOR = 2'd2;

  typedef struct packed {
    logic signed [CMD_W-1:0] cmd_x;
    logic signed [CMD_W-1:0] cmd_y;
  } sod_in_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] drive_x;
    logic signed [CMD_W-1:0] drive_y;
  } sod_out_t;

  typedef struct packed {
    logic [8:0]        sample_count;
    logic [15:0]       step_length;
    logic [FRAC_W-1:0] decay_factor;
  } sod_cfg_t;

endpackage

/* sv/sod_dser_mul.sv */
// Digit-serial unsigned multiplier, one 4-bit digit of b per cycle
module sod_dser_mul
  import sod_pkg::*;
#(
  parameter int WA = 16,
  parameter int WB = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic             done,
  output logic [WA+WB-1:0] prod
);

  localparam int ND  = (WB + 3) / 4;
  localparam int WBP = ND * 4;
  localparam int NW  = $clog2(ND + 1);

  logic [WA-1:0]      a_r;
  logic [WA+WBP-1:0]  p_r, p_nxt;
  logic [NW-1:0]      cnt_r;
  logic               busy_r, done_r;
  logic [WA+3:0]      sum;
  logic [WA+WBP+3:0]  ext;

  // Add one partial product to the upper half, shift the pair right a digit
  always_comb begin
    sum   = {4'b0, p_r[WA+WBP-1:WBP]} + (WA+4)'(a_r) * (WA+4)'(p_r[3:0]);
    ext   = {sum, p_r[WBP-1:0]};
    p_nxt = ext[WA+WBP+3:4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == NW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= NW'(ND);
      end else if (busy_r) begin
        cnt_r <= cnt_r - NW'(1);
        if (cnt_r == NW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Load operands, then step the product register
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      p_r <= {{WA{1'b0}}, WBP'(b)};
    end else if (busy_r) begin
      p_r <= p_nxt;
    end
  end

  assign done = done_r;
  assign prod = p_r[WA+WB-1:0];

endmodule

/* sv/sod_step_ctl.sv */
// Step and sub-step counters with the previous command
module sod_step_ctl
  import sod_pkg::*;
#(
  parameter int MAX_STEPS = 256,
  parameter int SW        = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  sod_cfg_t      cfg,
  input  logic          clr,
  input  logic          acc,
  input  sod_in_t       cmd,
  output logic [SW-1:0] step_index
);

  localparam int CW = (SW + 1 > 9) ? SW + 1 : 9;
  localparam logic [CW-1:0] MAX_N = CW'(MAX_STEPS);

  logic [SW-1:0] step_r, step_nxt;
  logic [15:0]   sub_r, sub_nxt;
  sod_in_t       prev_r;
  logic [CW-1:0] sc_ext, n_eff, last_step;
  logic [15:0]   slen_m1;
  logic          sub_end, step_end;

  // Clamp the register values to their working ranges
  always_comb begin
    sc_ext    = CW'(cfg.sample_count);
    n_eff     = (sc_ext == '0) ? CW'(1) : ((sc_ext > MAX_N) ? MAX_N : sc_ext);
    last_step = n_eff - CW'(1);
    slen_m1   = (cfg.step_length == 16'd0) ? 16'd0 : cfg.step_length - 16'd1;
    sub_end   = sub_r >= slen_m1;
    step_end  = CW'(step_r) >= last_step;
  end

  // Advance, wrap or restart the counters
  always_comb begin
    step_nxt = step_r;
    sub_nxt  = sub_r;
    if (clr) begin
      step_nxt = '0;
      sub_nxt  = '0;
    end else if (acc) begin
      if (sub_end && step_end) begin
        step_nxt = '0;
        sub_nxt  = '0;
      end else if (sub_end) begin
        step_nxt = step_r + SW'(1);
        sub_nxt  = '0;
      end else if (cmd != prev_r) begin
        step_nxt = '0;
        sub_nxt  = '0;
      end else begin
        sub_nxt = sub_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      sub_r  <= '0;
      prev_r <= '0;
    end else begin
      step_r <= step_nxt;
      sub_r  <= sub_nxt;
      if (acc) begin
        prev_r <= cmd;
      end
    end
  end

  assign step_index = step_r;

endmodule

/* sv/sod_round.sv */
// Rounds one axis decrease and forms the attenuated drive value
module sod_round
  import sod_pkg::*;
#(
  parameter int PW = 40
) (
  input  logic                    clk,
  input  logic                    load,
  input  logic [PW-1:0]           prod,
  input  logic                    neg,
  input  logic [CMD_W-1:0]        mag,
  output logic signed [CMD_W-1:0] drive
);

  localparam int DW = PW - FRAC_W + 1;

  logic [DW-1:0]    dmag, dmag_r;
  logic             neg_r;
  logic [CMD_W-1:0] mag_r;
  logic [CMD_W:0]   diff;
  logic             too_big;

  // Floor of a negative quotient rounds the magnitude up
  assign dmag = DW'(prod[PW-1:FRAC_W]) + DW'(neg && (prod[FRAC_W-1:0] != '0));

  // Hold the rounded decrease for the final step
  always_ff @(posedge clk) begin
    if (load) begin
      dmag_r <= dmag;
      neg_r  <= neg;
      mag_r  <= mag;
    end
  end

  // Drop to zero when the decrease exceeds the command
  always_comb begin
    too_big = dmag_r > DW'(mag_r);
    diff    = (CMD_W+1)'(mag_r) - dmag_r[CMD_W:0];
    if (too_big) begin
      drive = '0;
    end else if (neg_r) begin
      drive = CMD_W'(-diff);
    end else begin
      drive = CMD_W'(diff);
    end
  end

endmodule

/* sv/stepped_output_decay.sv */
// Top level of the stepped output decay block
//
//  channel  direction  ports                           payload
//  in       input      in_valid, in_stall, in_data     sod_in_t  (cmd_x, cmd_y)
//  out      output     out_valid, out_stall, out_data  sod_out_t (drive_x, drive_y)
//  cfg      input      cfg_we, cfg_idx, cfg_wdata      sample_count, step_length, decay_factor
//
// One item at a time, sequenced through the digit-serial multipliers:
// decay_factor times step index first, then both axis magnitudes times that
// factor, four digits each.
// Reset (rst_n low, synchronous) clears the counters and previous command and
// loads the register defaults.
// The finished item waits in the output register; a new item is taken meanwhile.
module stepped_output_decay
  import sod_pkg::*;
#(
  parameter int MAX_STEPS = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sod_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output sod_out_t         out_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int SW = $clog2(MAX_STEPS);
  localparam int KW = FRAC_W + SW;
  localparam int PW = CMD_W + KW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_KMUL = 2'd1;
  localparam logic [1:0] S_AMUL = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  sod_cfg_t         cfg_r;
  logic             cfg_clr;
  logic             acc;
  logic [SW-1:0]    step_index;
  logic [CMD_W-1:0] mag_x_r, mag_y_r;
  logic             neg_x_r, neg_y_r;
  logic             k_done, x_done, y_done;
  logic [KW-1:0]    f_k;
  logic [PW-1:0]    prod_x, prod_y;
  logic signed [CMD_W-1:0] drive_x, drive_y;
  logic             out_free;
  logic             out_valid_r;
  sod_out_t         out_data_r;

  assign acc      = in_valid && !in_stall;
  assign in_stall = state_r != S_IDLE;
  assign out_free = !out_valid_r || !out_stall;

  // Configuration registers; any valid write restarts the counters
  assign cfg_clr = cfg_we && (cfg_idx == REG_SAMPLE_COUNT || cfg_idx == REG_STEP_LENGTH ||
                              cfg_idx == REG_DECAY_FACTOR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_count <= 9'd1;
      cfg_r.step_length  <= 16'd1;
      cfg_r.decay_factor <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SAMPLE_COUNT: cfg_r.sample_count <= cfg_wdata[8:0];
        REG_STEP_LENGTH:  cfg_r.step_length  <= cfg_wdata;
        REG_DECAY_FACTOR: cfg_r.decay_factor <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sod_step_ctl #(.MAX_STEPS(MAX_STEPS), .SW(SW)) u_step_ctl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .clr        (cfg_clr),
    .acc        (acc),
    .cmd        (in_data),
    .step_index (step_index)
  );

  // Capture sign and magnitude of each axis
  always_ff @(posedge clk) begin
    if (acc) begin
      neg_x_r <= in_data.cmd_x[CMD_W-1];
      neg_y_r <= in_data.cmd_y[CMD_W-1];
      mag_x_r <= in_data.cmd_x[CMD_W-1] ? CMD_W'(-in_data.cmd_x) : in_data.cmd_x;
      mag_y_r <= in_data.cmd_y[CMD_W-1] ? CMD_W'(-in_data.cmd_y) : in_data.cmd_y;
    end
  end

  // Decay factor times step index
  sod_dser_mul #(.WA(FRAC_W), .WB(SW)) u_kmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (acc),
    .a     (cfg_r.decay_factor),
    .b     (step_index),
    .done  (k_done),
    .prod  (f_k)
  );

  // Axis magnitudes times the step factor
  sod_dser_mul #(.WA(KW), .WB(CMD_W)) u_xmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (k_done),
    .a     (f_k),
    .b     (mag_x_r),
    .done  (x_done),
    .prod  (prod_x)
  );

  sod_dser_mul #(.WA(KW), .WB(CMD_W)) u_ymul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (k_done),
    .a     (f_k),
    .b     (mag_y_r),
    .done  (y_done),
    .prod  (prod_y)
  );

  sod_round #(.PW(PW)) u_round_x (
    .clk   (clk),
    .load  (x_done),
    .prod  (prod_x),
    .neg   (neg_x_r),
    .mag   (mag_x_r),
    .drive (drive_x)
  );

  sod_round #(.PW(PW)) u_round_y (
    .clk   (clk),
    .load  (y_done),
    .prod  (prod_y),
    .neg   (neg_y_r),
    .mag   (mag_y_r),
    .drive (drive_y)
  );

  // Sequence one item through the multipliers
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (acc)      state_nxt = S_KMUL;
      S_KMUL: if (k_done)   state_nxt = S_AMUL;
      S_AMUL: if (x_done)   state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default:              state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hand the finished item to the output register
  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_data_r.drive_x <= drive_x;
      out_data_r.drive_y <= drive_y;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/stepped_output_decay_chk.sv */
// Port-level checker for the stepped output decay block, with its bind
`include "stepped_output_decay_macros.svh"

module stepped_output_decay_chk
  import sod_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input sod_out_t out_data
);

  // A stalled result stays offered and unchanged
  `SOD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "out_valid dropped while stalled")
  `SOD_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "out_data changed")

  // An accepted item keeps the input side busy through the multiply
  `SOD_ASSERT_NEXT(a_in_busy, in_valid && !in_stall, in_stall ##3 in_stall, "input freed early")

  // A new result only comes out of an item in progress
  `SOD_ASSERT_NOW(a_out_from_work, $rose(out_valid), $past(in_stall), "result without work")

endmodule

bind stepped_output_decay stepped_output_decay_chk u_chk (.*);

/* tb/sv/stepped_output_decay_test.sv */
// Self-checking testbench for the stepped output decay block
`timescale 1ns / 1ps

module stepped_output_decay_test;
  import sod_pkg::*;

  localparam int MAX_STEPS   = 256;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  // Index past the register list; writes to it must be ignored
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  // Mirror of the block: counters, previous command and the expected drive items
  class drive_tracker;
    bit [8:0]           samples_reg;
    bit [15:0]          step_len_reg;
    bit [15:0]          decay_reg;
    bit [7:0]           step_idx;
    bit [15:0]          sub_idx;
    logic signed [15:0] prev_x;
    logic signed [15:0] prev_y;
    sod_out_t           expected_drive[$];
    int                 errors;

    function new();
      samples_reg  = 9'd1;
      step_len_reg = 16'd1;
      decay_reg    = 16'd0;
      step_idx     = '0;
      sub_idx      = '0;
      prev_x       = '0;
      prev_y       = '0;
      errors       = 0;
    endfunction

    // Subtract floor(v * decay * step / 2^16), drop to zero when it overshoots
    function logic signed [15:0] attenuate(logic signed [15:0] v);
      longint mag;
      longint prod;
      longint dmag;
      longint r;
      mag  = (v < 0) ? -longint'(v) : longint'(v);
      prod = mag * longint'(decay_reg) * longint'(step_idx);
      dmag = (v < 0) ? ((prod + 65535) >> 16) : (prod >> 16);
      if (dmag > mag) return '0;
      r = (v < 0) ? longint'(v) + dmag : longint'(v) - dmag;
      return r[15:0];
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_SAMPLE_COUNT: samples_reg  = value[8:0];
        REG_STEP_LENGTH:  step_len_reg = value;
        REG_DECAY_FACTOR: decay_reg    = value;
        default: return;
      endcase
      step_idx = '0;
      sub_idx  = '0;
    endfunction

    // Predict the drive item for an accepted command, then advance the counters
    function void take_command(sod_in_t c);
      sod_out_t    r;
      int unsigned last_step;
      int unsigned slen;
      bit          sub_end;
      r.drive_x = attenuate(c.cmd_x);
      r.drive_y = attenuate(c.cmd_y);
      expected_drive.push_back(r);
      if (samples_reg == 0) last_step = 0;
      else if (samples_reg > MAX_STEPS) last_step = MAX_STEPS - 1;
      else last_step = samples_reg - 1;
      slen    = (step_len_reg == 0) ? 1 : step_len_reg;
      sub_end = (sub_idx >= slen - 1);
      if (sub_end && step_idx >= last_step) begin
        step_idx = '0;
        sub_idx  = '0;
      end else if (sub_end) begin
        step_idx = step_idx + 1;
        sub_idx  = '0;
      end else if (c.cmd_x != prev_x || c.cmd_y != prev_y) begin
        step_idx = '0;
        sub_idx  = '0;
      end else begin
        sub_idx = sub_idx + 1;
      end
      prev_x = c.cmd_x;
      prev_y = c.cmd_y;
    endfunction

    // Compare a drive item with the oldest prediction
    function void check_drive(sod_out_t got);
      sod_out_t want;
      if (expected_drive.size() == 0) begin
        $display("%0t: unexpected drive item x=%0d y=%0d", $time, got.drive_x, got.drive_y);
        errors++;
        return;
      end
      want = expected_drive.pop_front();
      if (got.drive_x !== want.drive_x) begin
        $display("%0t: drive_x expected %0d actual %0d", $time, want.drive_x, got.drive_x);
        errors++;
      end
      if (got.drive_y !== want.drive_y) begin
        $display("%0t: drive_y expected %0d actual %0d", $time, want.drive_y, got.drive_y);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  sod_in_t          in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  sod_out_t         out_data;
  logic             cfg_we    = 1'b0;
  logic [IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  drive_tracker tracker = new();
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  stepped_output_decay u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Check each accepted drive item
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_drive(out_data);
  end

  // Abort when neither channel moves an item for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Present one command, with random idle cycles ahead of it, and hold until taken
  task automatic send_cmd(input logic signed [15:0] x, input logic signed [15:0] y);
    sod_in_t c;
    c.cmd_x = x;
    c.cmd_y = y;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (in_stall);
    tracker.take_command(c);
  endtask

  // Drop valid and wait for every outstanding drive item
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.expected_drive.size() != 0);
  endtask

  // Write one register; the caller lowers the write enable after the last write
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    tracker.write_reg(idx, value);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] sc, input logic [CFG_W-1:0] sl,
                            input logic [CFG_W-1:0] df, input bit junk);
    write_reg(REG_SAMPLE_COUNT, sc);
    write_reg(REG_STEP_LENGTH, sl);
    write_reg(REG_DECAY_FACTOR, df);
    if (junk) write_reg(REG_UNUSED, 16'($urandom_range(65535)));
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    logic [CFG_W-1:0] sc;
    logic [CFG_W-1:0] sl;
    logic [CFG_W-1:0] df;
    case ($urandom_range(3))
      0: sc = 16'($urandom_range(65535));
      1: sc = 16'($urandom_range(8));
      2: sc = 16'($urandom_range(250, 260));
      default: sc = 16'($urandom_range(1, 40));
    endcase
    if ($urandom_range(3) == 0) sl = 16'($urandom_range(65535));
    else sl = 16'($urandom_range(4));
    df = 16'($urandom_range(65535) >> $urandom_range(12));
    set_config(sc, sl, df, bit'($urandom_range(1)));
  endtask

  // Half the time extremes and small values around zero, else the full range
  function automatic logic signed [15:0] pick_axis();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return 16'($urandom_range(16) - 8);
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // Runs of repeated commands with random content, plus lone and broken runs
  task automatic run_random(input int n_items);
    int sent;
    int len;
    int flip;
    int k;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        mask;
    sent = 0;
    while (sent < n_items) begin
      x = pick_axis();
      y = pick_axis();
      case ($urandom_range(9))
        0: begin
          send_cmd(x, y);
          sent++;
        end
        1: begin
          len  = $urandom_range(3, 12);
          flip = $urandom_range(1, len - 1);
          mask = 16'h1 << $urandom_range(15);
          for (k = 0; k < len; k++) begin
            if (k != flip) send_cmd(x, y);
            else if ($urandom_range(1)) send_cmd(x ^ mask, y);
            else send_cmd(x, y ^ mask);
          end
          sent += len;
        end
        default: begin
          len = $urandom_range(1, 40);
          repeat (len) send_cmd(x, y);
          sent += len;
        end
      endcase
    end
  endtask

  initial begin
    int phase;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: no decay, commands pass through
    send_cmd(16'sh7FFF, 16'sh8000);
    send_cmd(16'sh8000, 16'sh7FFF);
    send_cmd(16'sd0, -16'sd1);
    drain();

    // Full decay, one item per step: overshoot to zero from the third step on
    set_config(16'd256, 16'd1, 16'hFFFF, 1'b1);
    repeat (4) send_cmd(16'sh7FFF, 16'sh8000);
    send_cmd(16'sd1, -16'sd1);
    send_cmd(-16'sd1, 16'sd1);
    send_cmd(16'sd0, 16'sd0);
    drain();

    // Two steps of three items: advance, wrap, then a changed command clears
    set_config(16'd2, 16'd3, 16'h4000, 1'b0);
    repeat (4) send_cmd(16'sd20000, -16'sd12345);
    drain();
    // Unused index: ignored, counters keep running
    write_reg(REG_UNUSED, 16'hBEEF);
    cfg_we <= 1'b0;
    repeat (3) send_cmd(16'sd20000, -16'sd12345);
    send_cmd(16'sd20000, -16'sd12345);
    send_cmd(16'sd20001, -16'sd12345);
    send_cmd(16'sd20001, -16'sd12345);
    drain();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          idle_pct = 30;
          stall_pct <= 67;
          set_config(16'd256, 16'd1, 16'hFFFF, 1'b0);
        end
        1: begin
          idle_pct = 67;
          stall_pct <= 30;
          set_config(16'd0, 16'd0, 16'd1, 1'b1);
        end
        default: begin
          idle_pct = 0;
          stall_pct <= 0;
          set_config(16'hFFFF, 16'hFFFF, 16'h8000, 1'b0);
        end
      endcase
      run_random(120);
      drain();
      repeat (2) begin
        random_config();
        run_random(115);
        drain();
      end
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.expected_drive.size() != 0) begin
      $display("%0t: %0d drive items never arrived", $time, tracker.expected_drive.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/sod_pkg.sv
sv/sod_dser_mul.sv
sv/sod_step_ctl.sv
sv/sod_round.sv
sv/stepped_output_decay.sv
sv/stepped_output_decay_chk.sv
tb/sv/stepped_output_decay_test.sv
